### hdl/grpe_pkg.sv
// Shared types and constants for the glyph row pixel expander.
// No dependencies; every module of the block imports this package.
`default_nettype none

package grpe_pkg;

    localparam int STORE_BYTES     = 8192;
    localparam int STORE_AW        = $clog2(STORE_BYTES);
    localparam int MAX_CELL_WIDTH  = 16;
    localparam int MAX_CELL_HEIGHT = 16;

    // Configuration register indices
    localparam logic [2:0] REG_FRAME_BASE  = 3'd0;
    localparam logic [2:0] REG_LINE_PITCH  = 3'd1;
    localparam logic [2:0] REG_PIXEL_BYTES = 3'd2;
    localparam logic [2:0] REG_CELL_WIDTH  = 3'd3;
    localparam logic [2:0] REG_CELL_HEIGHT = 3'd4;
    localparam logic [2:0] REG_ROW_BYTES   = 3'd5;

    // Commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    localparam logic [7:0] SPACE_CODE = 8'h20;
    localparam logic [7:0] NULL_CODE  = 8'h00;

    typedef struct packed {
        logic        command;
        logic [7:0]  glyph_code;
        logic [3:0]  cell_row;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
        logic [12:0] load_addr;
        logic [7:0]  load_data;
    } item_t;

    typedef struct packed {
        logic [31:0] write_addr;
        logic [31:0] write_data;
        logic [2:0]  write_size;
        logic        last_pixel;
    } result_t;

    typedef struct packed {
        logic [31:0] frame_base;
        logic [15:0] line_pitch;
        logic [2:0]  pixel_bytes;
        logic [4:0]  cell_width;
        logic [4:0]  cell_height;
        logic [1:0]  row_bytes;
    } cfg_t;

    // Glyph store access from the sequencer
    typedef struct packed {
        logic                wr_en;
        logic [STORE_AW-1:0] wr_addr;
        logic [7:0]          wr_data;
        logic                rd_en;
        logic [STORE_AW-1:0] rd_addr;
    } ram_req_t;

endpackage

`default_nettype wire

### hdl/glyph_row_pixel_expander.sv
// Top level of the glyph row pixel expander: config registers, glyph store
// and row sequencer. Depends on grpe_pkg, grpe_cfg_regs, grpe_glyph_ram, grpe_row_seq.
//
//   channel   handshake                payload
//   command   start, busy              item   (grpe_pkg::item_t)
//   pixel     result_valid             result (grpe_pkg::result_t)
//   config    cfg_write                cfg_index, cfg_data
//
// A load transaction writes the glyph store at its accept edge; busy stays low.
// A draw holds busy after its accept edge through three address set-up states,
// two glyph store reads on the single read port, then one emit state per pixel.
// Each write reaches the ports in the cycle after its emit state,
// so the last one shares the first cycle in which a new transaction is accepted.
// A draw that produces nothing holds busy for one cycle.
// Reset clears control state and restores register defaults; the glyph store is
// not cleared. The receiver cannot stall.
`default_nettype none

module glyph_row_pixel_expander
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire grpe_pkg::item_t    item,
    output logic                    busy,
    output logic                    result_valid,
    output grpe_pkg::result_t       result,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import grpe_pkg::*;

    cfg_t     cfg;
    ram_req_t ram_req;
    logic [7:0] rd_data;

    grpe_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    grpe_glyph_ram u_ram
    (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    grpe_row_seq u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .ram_req      (ram_req),
        .rd_data      (rd_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

### hdl/grpe_cfg_regs.sv
// Configuration register file of the glyph row pixel expander.
// Depends on grpe_pkg for the register indices and cfg_t.
`default_nettype none

module grpe_cfg_regs
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output grpe_pkg::cfg_t          cfg
);
    import grpe_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_base  <= 32'd0;
            cfg_reg.line_pitch  <= 16'd4096;
            cfg_reg.pixel_bytes <= 3'd4;
            cfg_reg.cell_width  <= 5'd8;
            cfg_reg.cell_height <= 5'd16;
            cfg_reg.row_bytes   <= 2'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_BASE:  cfg_reg.frame_base  <= cfg_data;
                REG_LINE_PITCH:  cfg_reg.line_pitch  <= cfg_data[15:0];
                REG_PIXEL_BYTES: cfg_reg.pixel_bytes <= cfg_data[2:0];
                REG_CELL_WIDTH:  cfg_reg.cell_width  <= cfg_data[4:0];
                REG_CELL_HEIGHT: cfg_reg.cell_height <= cfg_data[4:0];
                REG_ROW_BYTES:   cfg_reg.row_bytes   <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hdl/grpe_glyph_ram.sv
// Glyph bitmap store: one write port, one read port, registered read data.
// Depends on grpe_pkg for ram_req_t and the store size.
`default_nettype none

module grpe_glyph_ram
(
    input  wire logic               clk,
    input  wire grpe_pkg::ram_req_t req,
    output logic [7:0]              rd_data
);
    import grpe_pkg::*;

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hdl/grpe_row_seq.sv
// Row sequencer: accepts commands, fetches the glyph row bytes and emits
// one pixel write per cycle. Depends on grpe_pkg.
`default_nettype none

module grpe_row_seq
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire grpe_pkg::cfg_t     cfg,
    input  wire logic               start,
    input  wire grpe_pkg::item_t    item,
    output logic                    busy,
    output grpe_pkg::ram_req_t      ram_req,
    input  wire logic [7:0]         rd_data,
    output logic                    result_valid,
    output grpe_pkg::result_t       result
);
    import grpe_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC1 = 3'd1;
    localparam logic [2:0] S_CALC2 = 3'd2;
    localparam logic [2:0] S_CALC3 = 3'd3;
    localparam logic [2:0] S_RD1   = 3'd4;
    localparam logic [2:0] S_RD2   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]          state_reg, state_next;
    item_t               item_reg;
    logic [12:0]         gh_reg;         // glyph code * height
    logic [12:0]         yrow_reg;
    logic [14:0]         px_off_reg;
    logic [STORE_AW-1:0] gbase_reg;
    logic [28:0]         line_off_reg;
    logic [31:0]         addr_reg;
    logic [15:0]         bits_reg;
    logic [3:0]          col_reg;
    logic                blank_reg;
    logic                result_valid_reg;
    result_t             result_reg;

    logic [4:0]          w_eff, h_eff;
    logic                accept, draw_ok, set_bit, last_col;
    logic [13:0]         gbase_full;
    logic [31:0]         pix_mask;

    assign w_eff = (cfg.cell_width > 5'(MAX_CELL_WIDTH)) ? 5'(MAX_CELL_WIDTH)
                                                         : cfg.cell_width;
    assign h_eff = (cfg.cell_height > 5'(MAX_CELL_HEIGHT)) ? 5'(MAX_CELL_HEIGHT)
                                                           : cfg.cell_height;

    assign accept  = start && (state_reg == S_IDLE);
    assign draw_ok = (cfg.pixel_bytes >= 3'd2) && (cfg.pixel_bytes <= 3'd4)
                     && (w_eff != 5'd0) && ({1'b0, item_reg.cell_row} < h_eff);

    assign gbase_full = (14'(gh_reg) + 14'(item_reg.cell_row)) * 14'(cfg.row_bytes);
    assign set_bit    = !blank_reg && bits_reg[4'd15 - col_reg];
    assign last_col   = ({1'b0, col_reg} == (w_eff - 5'd1));

    always_comb
    begin
        unique case (cfg.pixel_bytes)
            3'd2:    pix_mask = 32'h0000_FFFF;
            3'd3:    pix_mask = 32'h00FF_FFFF;
            default: pix_mask = 32'hFFFF_FFFF;
        endcase
    end

    always_comb
    begin
        ram_req.wr_en   = accept && (item.command == CMD_LOAD);
        ram_req.wr_addr = item.load_addr[STORE_AW-1:0];
        ram_req.wr_data = item.load_data;
        ram_req.rd_en   = (state_reg == S_CALC3) || (state_reg == S_RD1);
        ram_req.rd_addr = (state_reg == S_RD1) ? gbase_reg + STORE_AW'(1) : gbase_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.command == CMD_DRAW))
                begin
                    state_next = S_CALC1;
                end
            end
            S_CALC1: state_next = draw_ok ? S_CALC2 : S_IDLE;
            S_CALC2: state_next = S_CALC3;
            S_CALC3: state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_EMIT;
            S_EMIT:  state_next = last_col ? S_IDLE : S_EMIT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == S_EMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (state_reg == S_CALC1)
        begin
            gh_reg     <= 13'(item_reg.glyph_code * h_eff);
            yrow_reg   <= 13'(item_reg.pos_y) + 13'(item_reg.cell_row);
            px_off_reg <= 15'(item_reg.pos_x * cfg.pixel_bytes);
            blank_reg  <= (cfg.pixel_bytes == 3'd4)
                          && ((item_reg.glyph_code == SPACE_CODE)
                              || (item_reg.glyph_code == NULL_CODE));
        end
        if (state_reg == S_CALC2)
        begin
            gbase_reg    <= gbase_full[STORE_AW-1:0];
            line_off_reg <= 29'(yrow_reg * cfg.line_pitch);
        end
        if (state_reg == S_CALC3)
        begin
            addr_reg <= cfg.frame_base + 32'(line_off_reg) + 32'(px_off_reg);
            col_reg  <= 4'd0;
        end
        if (state_reg == S_RD1)
        begin
            bits_reg[15:8] <= rd_data;
        end
        if (state_reg == S_RD2)
        begin
            bits_reg[7:0] <= rd_data;
        end
        if (state_reg == S_EMIT)
        begin
            result_reg.write_addr <= addr_reg;
            result_reg.write_data <= (set_bit ? item_reg.fg_color : item_reg.bg_color)
                                     & pix_mask;
            result_reg.write_size <= cfg.pixel_bytes;
            result_reg.last_pixel <= last_col;
            addr_reg              <= addr_reg + 32'(cfg.pixel_bytes);
            col_reg               <= col_reg + 4'd1;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(state_reg == S_EMIT))
        else $error("result strobe without an emit cycle");

    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.last_pixel) |=> !result_valid_reg)
        else $error("write after the last pixel of a row");

    a_col_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> ({1'b0, col_reg} < w_eff))
        else $error("column beyond cell width");

    a_no_load_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.wr_en |-> (state_reg == S_IDLE))
        else $error("glyph store written during a draw");

endmodule

`default_nettype wire
